// ===== hdl/ogg_page_header_parser_assert.svh =====
// assertion macros of the ogg page header parser rtl
`ifndef OGG_PAGE_HEADER_PARSER_ASSERT_SVH
`define OGG_PAGE_HEADER_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define OPHP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define OPHP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ogg_php_pkg.sv =====
// types and constants of the ogg page header parser
package ogg_php_pkg;

   localparam logic [7:0] PAT_O = 8'h4F;
   localparam logic [7:0] PAT_G = 8'h67;
   localparam logic [7:0] PAT_S = 8'h53;
   localparam logic [8:0] HDR_FIXED = 9'd27;

   // parse phase: offset in the page header of the byte expected next
   localparam logic [4:0] PH_HUNT = 5'd0;
   localparam logic [4:0] PH_VERSION = 5'd4;
   localparam logic [4:0] PH_TYPE = 5'd5;
   localparam logic [4:0] PH_GRAN = 5'd6;
   localparam logic [4:0] PH_SERIAL = 5'd14;
   localparam logic [4:0] PH_SEQ = 5'd18;
   localparam logic [4:0] PH_CRC = 5'd22;
   localparam logic [4:0] PH_SEGS = 5'd26;
   localparam logic [4:0] PH_LACE = 5'd27;

   typedef struct packed {
      logic [7:0] data;
      logic is_s;
      logic is_zero;
   } byte_item_type;

   typedef struct packed {
      logic [7:0] page_flags;
      logic [63:0] granule_pos;
      logic [31:0] serial_number;
      logic [31:0] sequence_number;
      logic [31:0] page_checksum;
      logic [7:0] segment_count;
      logic [8:0] header_length;
      logic [15:0] body_length;
   } page_record_type;

endpackage

// ===== hdl/ogg_php_front.sv =====
// front end: two-beat byte queue that tags each byte for the parser
module ogg_php_front (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input logic [7:0] data_byte,
   output logic item_valid,
   output ogg_php_pkg::byte_item_type item,
   input logic item_take
);
   import ogg_php_pkg::*;

   byte_item_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic put;
   byte_item_type marked;

   assign full = (count_ff == 2'd2);
   assign put = push && !full;
   assign item_valid = (count_ff != 2'd0);
   assign item = slot_ff[rd_ptr_ff];

   always_comb begin
      marked.data = data_byte;
      marked.is_s = (data_byte == PAT_S);
      marked.is_zero = (data_byte == 8'd0);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ put;
      rd_ptr_in = rd_ptr_ff ^ item_take;
      count_in = count_ff + {1'b0, put} - {1'b0, item_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         slot_ff[wr_ptr_ff] <= marked;
      end
   end

endmodule

// ===== hdl/ogg_php_back.sv =====
// back end: capture-pattern hunt and page header field assembly
module ogg_php_back (
   input logic clock,
   input logic reset,
   input logic item_valid,
   input ogg_php_pkg::byte_item_type item,
   output logic item_take,
   input logic rec_full,
   output logic rec_push,
   output ogg_php_pkg::page_record_type rec
);
   import ogg_php_pkg::*;

   logic [23:0] window_ff, window_in;
   logic [4:0] phase_ff, phase_in;
   logic [7:0] type_ff, type_in;
   logic [63:0] granule_ff, granule_in;
   logic [31:0] serial_ff, serial_in;
   logic [31:0] sequence_ff, sequence_in;
   logic [31:0] crc_ff, crc_in;
   logic [7:0] segments_ff, segments_in;
   logic [7:0] lacing_left_ff, lacing_left_in;
   logic [15:0] body_ff, body_in;
   logic hit;
   logic [4:0] offset;
   logic [7:0] b;

   assign item_take = item_valid && !rec_full;
   assign b = item.data;
   assign hit = (window_ff == {PAT_O, PAT_G, PAT_G}) && item.is_s;

   always_comb begin
      window_in = window_ff;
      phase_in = phase_ff;
      type_in = type_ff;
      granule_in = granule_ff;
      serial_in = serial_ff;
      sequence_in = sequence_ff;
      crc_in = crc_ff;
      segments_in = segments_ff;
      lacing_left_in = lacing_left_ff;
      body_in = body_ff;
      rec_push = 1'b0;
      offset = 5'd0;
      if (item_take) begin
         priority if (phase_ff == PH_HUNT) begin
            window_in = {window_ff[15:0], b};
            if (hit) begin
               window_in = 24'd0;
               phase_in = PH_VERSION;
               type_in = 8'd0;
               granule_in = 64'd0;
               serial_in = 32'd0;
               sequence_in = 32'd0;
               crc_in = 32'd0;
               segments_in = 8'd0;
               lacing_left_in = 8'd0;
               body_in = 16'd0;
            end
         end else if (phase_ff == PH_VERSION) begin
            if (item.is_zero) begin
               phase_in = PH_TYPE;
            end else begin
               phase_in = PH_HUNT;
               window_in = 24'd0;
            end
         end else if (phase_ff == PH_TYPE) begin
            type_in = b;
            phase_in = PH_GRAN;
         end else if (phase_ff >= PH_GRAN && phase_ff < PH_SERIAL) begin
            offset = phase_ff - PH_GRAN;
            granule_in[offset[2:0]*8 +: 8] = b;
            phase_in = phase_ff + 5'd1;
         end else if (phase_ff >= PH_SERIAL && phase_ff < PH_SEQ) begin
            offset = phase_ff - PH_SERIAL;
            serial_in[offset[1:0]*8 +: 8] = b;
            phase_in = phase_ff + 5'd1;
         end else if (phase_ff >= PH_SEQ && phase_ff < PH_CRC) begin
            offset = phase_ff - PH_SEQ;
            sequence_in[offset[1:0]*8 +: 8] = b;
            phase_in = phase_ff + 5'd1;
         end else if (phase_ff >= PH_CRC && phase_ff < PH_SEGS) begin
            offset = phase_ff - PH_CRC;
            crc_in[offset[1:0]*8 +: 8] = b;
            phase_in = phase_ff + 5'd1;
         end else if (phase_ff == PH_SEGS) begin
            segments_in = b;
            lacing_left_in = b;
            body_in = 16'd0;
            if (item.is_zero) begin
               rec_push = 1'b1;
               phase_in = PH_HUNT;
               window_in = 24'd0;
            end else begin
               phase_in = PH_LACE;
            end
         end else if (phase_ff == PH_LACE && lacing_left_ff != 8'd0) begin
            body_in = body_ff + {8'd0, b};
            lacing_left_in = lacing_left_ff - 8'd1;
            if (lacing_left_ff == 8'd1) begin
               rec_push = 1'b1;
               phase_in = PH_HUNT;
               window_in = 24'd0;
            end
         end else begin
            // phase with no meaning: back to hunting, byte not hunted
            phase_in = PH_HUNT;
            window_in = 24'd0;
         end
      end
   end

   always_comb begin
      rec.page_flags = type_in;
      rec.granule_pos = granule_in;
      rec.serial_number = serial_in;
      rec.sequence_number = sequence_in;
      rec.page_checksum = crc_in;
      rec.segment_count = segments_in;
      rec.header_length = HDR_FIXED + {1'b0, segments_in};
      rec.body_length = body_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 24'd0;
         phase_ff <= PH_HUNT;
         type_ff <= 8'd0;
         granule_ff <= 64'd0;
         serial_ff <= 32'd0;
         sequence_ff <= 32'd0;
         crc_ff <= 32'd0;
         segments_ff <= 8'd0;
         lacing_left_ff <= 8'd0;
         body_ff <= 16'd0;
      end else begin
         window_ff <= window_in;
         phase_ff <= phase_in;
         type_ff <= type_in;
         granule_ff <= granule_in;
         serial_ff <= serial_in;
         sequence_ff <= sequence_in;
         crc_ff <= crc_in;
         segments_ff <= segments_in;
         lacing_left_ff <= lacing_left_in;
         body_ff <= body_in;
      end
   end

`include "ogg_page_header_parser_assert.svh"

`OPHP_ASSERT_NOW(a_emit_phase, rec_push, (phase_ff == PH_SEGS) || (phase_ff == PH_LACE), "record outside segment phases")
`OPHP_ASSERT_NEXT(a_emit_rehunt, rec_push, (phase_ff == PH_HUNT) && (window_ff == 24'd0), "no clean hunt after record")
`OPHP_ASSERT_NEXT(a_hit_clear, item_take && (phase_ff == PH_HUNT) && hit, (phase_ff == PH_VERSION) && (granule_ff == 64'd0), "header not cleared on pattern")
`OPHP_ASSERT_NOW(a_lace_left, phase_ff == PH_LACE, lacing_left_ff != 8'd0, "lacing phase with no bytes left")

endmodule

// ===== hdl/ogg_php_rspq.sv =====
// result queue: two header records waiting for the consumer
module ogg_php_rspq (
   input logic clock,
   input logic reset,
   input logic rec_push,
   input ogg_php_pkg::page_record_type rec,
   output logic rec_full,
   input logic pop,
   output logic empty,
   output ogg_php_pkg::page_record_type head
);
   import ogg_php_pkg::*;

   page_record_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic take;

   assign rec_full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign take = pop && !empty;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ rec_push;
      rd_ptr_in = rd_ptr_ff ^ take;
      count_in = count_ff + {1'b0, rec_push} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_push) begin
         slot_ff[wr_ptr_ff] <= rec;
      end
   end

endmodule

// ===== hdl/ogg_page_header_parser.sv =====
// top level of the ogg page header parser
//
// takes a raw ogg container stream one byte per input beat and returns one
// record per well-formed page header: type flags, granule position, serial,
// sequence and checksum words, segment count, header length (27 plus the
// segment count) and body length (sum of the lacing values). the capture
// pattern is found by a sliding match at every byte offset while hunting;
// a page whose version byte is not zero is dropped, and page bodies simply
// pass through the hunt. one byte is consumed per clock cycle; the rate is
// set by the parser's single byte-wide assembly step, and the result queue
// never holds up input as long as records are popped. each pushed byte is
// first registered in the front queue; the parser writes the record into
// the result queue in the cycle it takes the last header byte, and the
// record is on the result ports, ready to pop, in the next cycle.
module ogg_page_header_parser (
   input logic clock,
   input logic reset,
   // input beat: one stream byte
   input logic push,
   output logic full,
   input logic [7:0] req_data_byte,
   // result beat: one page header record
   output logic empty,
   input logic pop,
   output logic [7:0] rsp_page_flags,
   output logic [63:0] rsp_granule_pos,
   output logic [31:0] rsp_serial_number,
   output logic [31:0] rsp_sequence_number,
   output logic [31:0] rsp_page_checksum,
   output logic [7:0] rsp_segment_count,
   output logic [8:0] rsp_header_length,
   output logic [15:0] rsp_body_length
);
   import ogg_php_pkg::*;

   // front to back: tagged byte queue
   logic item_valid;
   logic item_take;
   byte_item_type item;

   // back to result queue
   logic rec_push;
   logic rec_full;
   page_record_type rec;
   page_record_type head;

   // accepts bytes and tags them while the parser is busy or stalled
   ogg_php_front u_front (
      .clock (clock),
      .reset (reset),
      .push (push),
      .full (full),
      .data_byte (req_data_byte),
      .item_valid (item_valid),
      .item (item),
      .item_take (item_take)
   );

   // hunt and header assembly, one byte per cycle while the result queue has room
   ogg_php_back u_back (
      .clock (clock),
      .reset (reset),
      .item_valid (item_valid),
      .item (item),
      .item_take (item_take),
      .rec_full (rec_full),
      .rec_push (rec_push),
      .rec (rec)
   );

   // finished records wait here for the consumer
   ogg_php_rspq u_rspq (
      .clock (clock),
      .reset (reset),
      .rec_push (rec_push),
      .rec (rec),
      .rec_full (rec_full),
      .pop (pop),
      .empty (empty),
      .head (head)
   );

   assign rsp_page_flags = head.page_flags;
   assign rsp_granule_pos = head.granule_pos;
   assign rsp_serial_number = head.serial_number;
   assign rsp_sequence_number = head.sequence_number;
   assign rsp_page_checksum = head.page_checksum;
   assign rsp_segment_count = head.segment_count;
   assign rsp_header_length = head.header_length;
   assign rsp_body_length = head.body_length;

endmodule

// ===== sim/ogg_page_header_parser_tb.sv =====
// self-checking testbench of the ogg page header parser: byte stream in, page records out
module ogg_page_header_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ogg_php_pkg::*;

   // bytes to queue in all, random part stops once the stream holds this many
   localparam int unsigned ITEM_TARGET = 1750;
   // random part keeps going until this many well-formed pages were queued
   localparam int unsigned MIN_PAGES = 20;
   // no idling once fewer bytes than this are left to send
   localparam int unsigned TAIL_BYTES = 200;
   // long receiver hold-off that lets the record queue fill and stall the input
   localparam int unsigned HOLD_AFTER = 12;
   localparam int unsigned HOLD_CYCLES = 3000;
   // cycles with no beat on either side before the run is given up
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   // drain time after the last owed record, as margin
   localparam int unsigned DRAIN_CYCLES = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [7:0] req_data_byte = 8'h00;
   logic empty;
   logic pop = 1'b0;
   logic [7:0] rsp_page_flags;
   logic [63:0] rsp_granule_pos;
   logic [31:0] rsp_serial_number;
   logic [31:0] rsp_sequence_number;
   logic [31:0] rsp_page_checksum;
   logic [7:0] rsp_segment_count;
   logic [8:0] rsp_header_length;
   logic [15:0] rsp_body_length;

   ogg_page_header_parser dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data_byte(req_data_byte),
      .empty(empty),
      .pop(pop),
      .rsp_page_flags(rsp_page_flags),
      .rsp_granule_pos(rsp_granule_pos),
      .rsp_serial_number(rsp_serial_number),
      .rsp_sequence_number(rsp_sequence_number),
      .rsp_page_checksum(rsp_page_checksum),
      .rsp_segment_count(rsp_segment_count),
      .rsp_header_length(rsp_header_length),
      .rsp_body_length(rsp_body_length)
   );

   // 10 ns period
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // bytes still to send, oldest first
   logic [7:0] stream_bytes[$];
   // page records the parser owes us, oldest first
   page_record_type expected_pages[$];

   // parser mirror: hunt window, header offset, fields being assembled
   logic [23:0] hunt_window = '0;
   logic [4:0] header_offset = PH_HUNT;
   page_record_type page_fields = '0;
   logic [7:0] lacing_to_go = '0;

   int unsigned records_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned pages_made = 0;

   // idle burst and run bookkeeping of both sides
   int unsigned send_idle_left = 0;
   int unsigned send_run_left = 0;
   int unsigned rcv_idle_left = 0;
   int unsigned rcv_run_left = 0;
   int unsigned hold_left = 0;
   bit hold_done = 1'b0;
   int unsigned quiet_cycles = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("record %0d %s got %0h want %0h",
                                   records_seen, name, got, want));
      end
   endtask

   // -------------------------------------------------------------------------
   // page header prediction
   // -------------------------------------------------------------------------

   // header complete: owe a record and go back to hunting with a clean window
   task automatic finish_page();
      expected_pages.push_back(page_fields);
      header_offset = PH_HUNT;
      hunt_window = '0;
   endtask

   // advance the parser mirror by one accepted byte
   task automatic parse_byte(input logic [7:0] b);
      if (header_offset == PH_HUNT) begin
         if (hunt_window == {PAT_O, PAT_G, PAT_G} && b == PAT_S) begin
            // capture pattern: start a fresh header
            hunt_window = '0;
            page_fields = '0;
            lacing_to_go = '0;
            header_offset = PH_VERSION;
         end else begin
            hunt_window = {hunt_window[15:0], b};
         end
      end else if (header_offset == PH_VERSION) begin
         if (b != 8'h00) begin
            // unknown version: drop the page, the version byte is not hunted
            header_offset = PH_HUNT;
            hunt_window = '0;
         end else begin
            header_offset = PH_TYPE;
         end
      end else if (header_offset == PH_TYPE) begin
         page_fields.page_flags = b;
         header_offset = PH_GRAN;
      end else if (header_offset < PH_SERIAL) begin
         page_fields.granule_pos = page_fields.granule_pos
            | (64'(b) << (8 * (header_offset - PH_GRAN)));
         header_offset = header_offset + 5'd1;
      end else if (header_offset < PH_SEQ) begin
         page_fields.serial_number = page_fields.serial_number
            | (32'(b) << (8 * (header_offset - PH_SERIAL)));
         header_offset = header_offset + 5'd1;
      end else if (header_offset < PH_CRC) begin
         page_fields.sequence_number = page_fields.sequence_number
            | (32'(b) << (8 * (header_offset - PH_SEQ)));
         header_offset = header_offset + 5'd1;
      end else if (header_offset < PH_SEGS) begin
         page_fields.page_checksum = page_fields.page_checksum
            | (32'(b) << (8 * (header_offset - PH_CRC)));
         header_offset = header_offset + 5'd1;
      end else if (header_offset == PH_SEGS) begin
         page_fields.segment_count = b;
         page_fields.header_length = HDR_FIXED + 9'(b);
         page_fields.body_length = '0;
         lacing_to_go = b;
         // no segments: the record closes on the count byte itself
         if (b == 8'h00) begin
            finish_page();
         end else begin
            header_offset = PH_LACE;
         end
      end else if (header_offset == PH_LACE && lacing_to_go != 8'h00) begin
         page_fields.body_length = page_fields.body_length + 16'(b);
         lacing_to_go = lacing_to_go - 8'd1;
         if (lacing_to_go == 8'h00) begin
            finish_page();
         end
      end else begin
         header_offset = PH_HUNT;
         hunt_window = '0;
      end
   endtask

   // -------------------------------------------------------------------------
   // stream building
   // -------------------------------------------------------------------------

   task automatic queue_byte(input logic [7:0] b);
      stream_bytes.push_back(b);
   endtask

   task automatic queue_capture();
      queue_byte(PAT_O);
      queue_byte(PAT_G);
      queue_byte(PAT_G);
      queue_byte(PAT_S);
   endtask

   // full 27 byte page header, lacing bytes follow separately
   task automatic queue_header(input logic [7:0] version, input logic [7:0] htype,
                               input logic [63:0] granule, input logic [31:0] serial,
                               input logic [31:0] seqn, input logic [31:0] crc,
                               input logic [7:0] segs);
      queue_capture();
      queue_byte(version);
      queue_byte(htype);
      for (int i = 0; i < 8; i++) queue_byte(granule[8*i +: 8]);
      for (int i = 0; i < 4; i++) queue_byte(serial[8*i +: 8]);
      for (int i = 0; i < 4; i++) queue_byte(seqn[8*i +: 8]);
      for (int i = 0; i < 4; i++) queue_byte(crc[8*i +: 8]);
      queue_byte(segs);
   endtask

   // bytes leaning toward the pattern letters and zero
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0: return PAT_O;
         1: return PAT_G;
         2: return PAT_S;
         3: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   // well-formed page with random content, mostly few segments
   task automatic queue_random_page();
      int unsigned pick;
      int unsigned segs;
      bit all_max;
      pick = $urandom_range(0, 99);
      if (pick < 15) segs = 0;
      else if (pick < 85) segs = $urandom_range(1, 6);
      else if (pick < 97) segs = $urandom_range(7, 40);
      else segs = $urandom_range(200, 255);
      all_max = ($urandom_range(0, 9) == 0);
      queue_header(8'h00, 8'($urandom), {$urandom, $urandom}, $urandom, $urandom,
                   $urandom, 8'(segs));
      for (int i = 0; i < segs; i++) begin
         queue_byte(all_max ? 8'hFF : 8'($urandom));
      end
      // a short stand-in for the body, the hunt walks over it
      repeat ($urandom_range(0, 12)) queue_byte(noise_byte());
      pages_made++;
   endtask

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------

   initial begin : build_stream
      int unsigned pick;
      // byte extremes with no pattern around
      queue_byte(8'h00);
      queue_byte(8'hFF);
      // smallest page: no segments, every field zero
      queue_header(8'h00, 8'h00, '0, '0, '0, '0, 8'd0);
      // largest page: every field all ones, 255 lacing values of 255
      queue_header(8'h00, 8'hFF, '1, '1, '1, '1, 8'd255);
      repeat (255) queue_byte(8'hFF);
      // sliding match over a repeated first letter
      queue_byte(PAT_O);
      queue_header(8'h00, 8'h02, 64'h0123_4567_89AB_CDEF, 32'h1122_3344, 32'h0,
                   32'hDEAD_BEEF, 8'd1);
      queue_byte(8'h00);
      // sliding match after a false start of two letters
      queue_byte(PAT_O);
      queue_byte(PAT_G);
      queue_header(8'h00, 8'h01, 64'h8000_0000_0000_0001, 32'h8000_0001, 32'd1,
                   32'h7FFF_FFFE, 8'd2);
      queue_byte(8'd1);
      queue_byte(8'd254);
      // sliding match after a false start of three letters
      queue_byte(PAT_O);
      queue_byte(PAT_G);
      queue_byte(PAT_G);
      queue_header(8'h00, 8'h04, 64'hFFFF_FFFF_0000_0000, 32'h0, 32'hFFFF_FFFF,
                   32'h0, 8'd0);
      // almost a pattern, last letter wrong
      queue_byte(PAT_O);
      queue_byte(PAT_G);
      queue_byte(PAT_G);
      queue_byte(8'h00);
      // unknown versions drop the page
      queue_capture();
      queue_byte(8'h01);
      queue_capture();
      queue_byte(8'h80);
      // version byte is a letter of the pattern: window was cleared, no page
      queue_capture();
      queue_byte(PAT_O);
      queue_byte(PAT_G);
      queue_byte(PAT_G);
      queue_byte(PAT_S);
      // lacing bytes spell the pattern start and an S follows: no page from it
      queue_header(8'h00, 8'h00, 64'd5, 32'd6, 32'd7, 32'd8, 8'd3);
      queue_byte(PAT_O);
      queue_byte(PAT_G);
      queue_byte(PAT_G);
      queue_byte(PAT_S);
      // record on the count byte, then a lone S
      queue_header(8'h00, 8'h05, 64'd9, 32'd10, 32'd11, 32'd12, 8'd0);
      queue_byte(PAT_S);
      // header words that carry the pattern are never hunted
      queue_header(8'h00, PAT_O, {2{PAT_O, PAT_G, PAT_G, PAT_S}},
                   {PAT_O, PAT_G, PAT_G, PAT_S}, {PAT_S, PAT_G, PAT_G, PAT_O},
                   {PAT_O, PAT_G, PAT_G, PAT_S}, 8'd1);
      queue_byte(PAT_S);
      // back to back pages, no gap
      queue_header(8'h00, 8'h06, 64'd1, 32'd2, 32'd3, 32'd4, 8'd1);
      queue_byte(8'h80);
      queue_header(8'h00, 8'h07, 64'd2, 32'd3, 32'd4, 32'd5, 8'd2);
      queue_byte(8'h7F);
      queue_byte(8'h81);
      // cut-off header: the next page's bytes become its fields
      queue_capture();
      queue_byte(8'h00);
      queue_byte(8'h06);
      queue_header(8'h00, 8'h00, 64'd3, 32'd4, 32'd5, 32'd6, 8'd0);

      // random part: mostly well-formed pages, some noise and broken pages
      while (stream_bytes.size() < ITEM_TARGET || pages_made < MIN_PAGES) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            queue_random_page();
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 16)) queue_byte(noise_byte());
         end else if (pick < 87) begin
            queue_capture();
            queue_byte(8'($urandom_range(1, 255)));
         end else if (pick < 93) begin
            queue_capture();
            queue_byte(8'h00);
            repeat ($urandom_range(1, 22)) queue_byte(8'($urandom));
         end else begin
            queue_byte(PAT_O);
            if ($urandom_range(0, 1) == 1) queue_byte(PAT_G);
            if ($urandom_range(0, 1) == 1) queue_byte(PAT_G);
            queue_byte(noise_byte());
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all bytes in, then every owed record out, then a short drain
      while (stream_bytes.size() != 0) @(posedge clock);
      while (expected_pages.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS ogg_page_header_parser");
      end else begin
         $display("FAIL ogg_page_header_parser");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // input side: drive at the falling edge, take at the rising edge
   // -------------------------------------------------------------------------

   always @(negedge clock) begin : offer_bytes
      logic offer;
      logic calm;
      offer = 1'b0;
      calm = (stream_bytes.size() < TAIL_BYTES);
      if (!reset && stream_bytes.size() != 0) begin
         if (calm) send_idle_left = 0;
         if (send_idle_left != 0) begin
            send_idle_left--;
         end else begin
            offer = 1'b1;
            if (send_run_left != 0) begin
               send_run_left--;
            end else if (!calm) begin
               // next: an idle burst or a stretch of back to back beats
               if ($urandom_range(0, 2) == 0) send_idle_left = $urandom_range(1, 18);
               else send_run_left = $urandom_range(1, 60);
            end
         end
      end
      push <= offer;
      // junk on the data port while not pushing
      req_data_byte <= offer ? stream_bytes[0] : 8'($urandom);
   end

   always @(posedge clock) begin : take_byte
      if (!reset && push && !full) begin
         parse_byte(req_data_byte);
         stream_bytes.delete(0);
      end
   end

   // -------------------------------------------------------------------------
   // result side: pop with stalls and one long hold-off, check every beat
   // -------------------------------------------------------------------------

   always @(negedge clock) begin : drive_pop
      logic take;
      logic calm;
      take = 1'b0;
      calm = (stream_bytes.size() < TAIL_BYTES);
      if (!reset) begin
         // hold off long enough for the record queue to fill and block input
         if (!hold_done && !calm && records_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (calm) rcv_idle_left = 0;
         if (hold_left != 0) begin
            hold_left--;
         end else if (rcv_idle_left != 0) begin
            rcv_idle_left--;
         end else begin
            take = 1'b1;
            if (rcv_run_left != 0) begin
               rcv_run_left--;
            end else if (!calm) begin
               if ($urandom_range(0, 2) == 0) rcv_idle_left = $urandom_range(1, 18);
               else rcv_run_left = $urandom_range(1, 60);
            end
         end
      end
      pop <= take;
   end

   always @(posedge clock) begin : check_record
      page_record_type want;
      if (!reset && pop && !empty) begin
         if (expected_pages.size() == 0) begin
            report_mismatch($sformatf("record %0d arrived with none owed", records_seen));
         end else begin
            want = expected_pages.pop_front();
            check_field("page_flags", 64'(rsp_page_flags), 64'(want.page_flags));
            check_field("granule_pos", rsp_granule_pos, want.granule_pos);
            check_field("serial_number", 64'(rsp_serial_number),
                        64'(want.serial_number));
            check_field("sequence_number", 64'(rsp_sequence_number),
                        64'(want.sequence_number));
            check_field("page_checksum", 64'(rsp_page_checksum),
                        64'(want.page_checksum));
            check_field("segment_count", 64'(rsp_segment_count),
                        64'(want.segment_count));
            check_field("header_length", 64'(rsp_header_length),
                        64'(want.header_length));
            check_field("body_length", 64'(rsp_body_length), 64'(want.body_length));
         end
         records_seen++;
      end
   end

   // -------------------------------------------------------------------------
   // watchdog: too long without a beat on either side means a hang
   // -------------------------------------------------------------------------

   always @(posedge clock) begin : watchdog
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a beat", quiet_cycles);
         $display("FAIL ogg_page_header_parser");
         $finish;
      end
   end

endmodule

// ===== ogg_page_header_parser.f =====
+incdir+hdl
hdl/ogg_php_pkg.sv
hdl/ogg_php_front.sv
hdl/ogg_php_back.sv
hdl/ogg_php_rspq.sv
hdl/ogg_page_header_parser.sv
sim/ogg_page_header_parser_tb.sv
